### rtl/retry_backoff_event_scheduler_assert.svh
// Assertion macros for the retry/backoff event scheduler.
// Both sample on clk and are disabled while rst is high.
`ifndef RETRY_BACKOFF_EVENT_SCHEDULER_ASSERT_SVH
`define RETRY_BACKOFF_EVENT_SCHEDULER_ASSERT_SVH

// Consequent must hold in the same cycle.
`define RBES_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// Consequent must hold in the next cycle.
`define RBES_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

### rtl/rbes_pkg.sv
package rbes_pkg;

  localparam int TIME_WIDTH_DEF = 32;
  localparam int TAG_WIDTH_DEF  = 32;

  localparam int IN_DATA_W  = 144;
  localparam int OUT_DATA_W = 56;
  localparam int CFG_DATA_W = 20;
  localparam int RECON_W    = 20;

  localparam logic [15:0] COOLDOWN_BASE_RST  = 16'd100;
  localparam logic [15:0] COOLDOWN_MAX_RST   = 16'd60000;
  localparam logic [15:0] TELEM_IDLE_RST     = 16'd4000;
  localparam logic [15:0] TELEM_BUSY_RST     = 16'd1000;
  localparam logic [19:0] RECONNECT_RST      = 20'd10000;
  localparam logic [2:0]  GIVE_UP_RST        = 3'd5;

  typedef enum logic [1:0] {
    OP_QUERY = 2'd0,
    OP_DONE  = 2'd1,
    OP_POST  = 2'd2,
    OP_RESET = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    DONE_OK      = 2'd0,
    DONE_REFUSED = 2'd1,
    DONE_FAILED  = 2'd2
  } done_t;

  typedef enum logic [1:0] {
    ACT_NONE      = 2'd0,
    ACT_SLEEP     = 2'd1,
    ACT_EVENT     = 2'd2,
    ACT_TELEMETRY = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    XFER_NONE     = 2'd0,
    XFER_FINISHED = 2'd1,
    XFER_ERROR    = 2'd2,
    XFER_STOPPED  = 2'd3
  } xfer_t;

  typedef enum logic [2:0] {
    CFG_COOLDOWN_BASE = 3'd0,
    CFG_COOLDOWN_MAX  = 3'd1,
    CFG_TELEM_IDLE    = 3'd2,
    CFG_TELEM_BUSY    = 3'd3,
    CFG_RECONNECT     = 3'd4,
    CFG_GIVE_UP       = 3'd5
  } cfg_idx_t;

  localparam logic [3:0] EV_INFO          = 4'd0;
  localparam logic [3:0] EV_STOPPED       = 4'd8;
  localparam logic [3:0] EV_ABORTED       = 4'd9;
  localparam logic [3:0] EV_XFER_FINISHED = 4'd10;
  localparam logic [3:0] EV_LAST          = 4'd10;

  typedef struct packed {
    logic        rescan_files;
    logic [31:0] event_tag;
    logic [3:0]  event_type;
    logic [15:0] sleep_ms;
    action_t     action;
  } result_t;

endpackage

### rtl/retry_backoff_event_scheduler.sv
// Retry/backoff event scheduler.
// Input channel s_*: one operation per item (query, attempt done, post event,
// reset), op in s_tuser, the other fields in s_tdata. Output channel m_*: one
// result per item, action in m_tuser, sleep/event fields in m_tdata.
// Configuration: cfg_we/cfg_index/cfg_data write one register per edge; write
// only while no item is in flight.
// Latency: the result of an item is on m_* the cycle after it is accepted when
// the output register is free; otherwise it waits in the skid register.
// Throughput: one item per cycle while s_tready is high; all state is updated by a single pass of
// compare/subtract logic at the accepting edge.
// A two-entry output buffer (output register plus skid register) keeps
// s_tready high while one result waits; s_tready is low whenever the skid
// register holds a result, i.e. from the cycle after a second result arrives
// with m_tready low until the output register is taken.
// Reset (rst, synchronous): configuration returns to its defaults, the
// scheduler state clears with info marked dirty, the output buffer empties.
`include "retry_backoff_event_scheduler_assert.svh"

module retry_backoff_event_scheduler #(
  parameter int TIME_WIDTH = rbes_pkg::TIME_WIDTH_DEF,
  parameter int TAG_WIDTH  = rbes_pkg::TAG_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // now_ms, done_result, info hash, file listing hash, is_busy,
  // transfer_outcome, post_type, post_tag, zero pad
  input  logic [rbes_pkg::IN_DATA_W-1:0]   s_tdata,
  // op
  input  logic [1:0]                       s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // sleep_ms, event_type, event_tag, rescan_files, zero pad
  output logic [rbes_pkg::OUT_DATA_W-1:0]  m_tdata,
  // action
  output logic [1:0]                       m_tuser,
  input  logic                             cfg_we,
  input  logic [2:0]                       cfg_index,
  input  logic [rbes_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rbes_pkg::*;

  localparam int CMP_W = (TIME_WIDTH > RECON_W) ? TIME_WIDTH : RECON_W;

  // configuration
  logic [15:0] cooldown_base_ms, cooldown_max_ms, telemetry_idle_ms, telemetry_busy_ms;
  logic [19:0] reconnect_after_ms;
  logic [2:0]  give_up_attempts;

  always_ff @(posedge clk) begin
    if (rst) begin
      cooldown_base_ms   <= COOLDOWN_BASE_RST;
      cooldown_max_ms    <= COOLDOWN_MAX_RST;
      telemetry_idle_ms  <= TELEM_IDLE_RST;
      telemetry_busy_ms  <= TELEM_BUSY_RST;
      reconnect_after_ms <= RECONNECT_RST;
      give_up_attempts   <= GIVE_UP_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_COOLDOWN_BASE: cooldown_base_ms   <= cfg_data[15:0];
        CFG_COOLDOWN_MAX:  cooldown_max_ms    <= cfg_data[15:0];
        CFG_TELEM_IDLE:    telemetry_idle_ms  <= cfg_data[15:0];
        CFG_TELEM_BUSY:    telemetry_busy_ms  <= cfg_data[15:0];
        CFG_RECONNECT:     reconnect_after_ms <= cfg_data[19:0];
        CFG_GIVE_UP:       give_up_attempts   <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // input fields
  op_t                   op;
  logic [TIME_WIDTH-1:0] now;
  logic [1:0]            done_result;
  logic [31:0]           info_hash, file_list_hash, post_tag;
  logic                  is_busy;
  xfer_t                 transfer_outcome;
  logic [3:0]            post_type;

  assign op               = op_t'(s_tuser);
  assign now              = TIME_WIDTH'(s_tdata[31:0]);
  assign done_result      = s_tdata[33:32];
  assign info_hash        = s_tdata[65:34];
  assign file_list_hash   = s_tdata[97:66];
  assign is_busy          = s_tdata[98];
  assign transfer_outcome = xfer_t'(s_tdata[100:99]);
  assign post_type        = s_tdata[104:101];
  assign post_tag         = s_tdata[136:105];

  // scheduler state
  logic [15:0]           retry_delay, retry_delay_next;
  logic                  retry_delay_valid, retry_delay_valid_next;
  logic                  sleep_pending, sleep_pending_next;
  logic [2:0]            fail_count, fail_count_next;
  logic                  pending_valid, pending_valid_next;
  logic [3:0]            pending_type, pending_type_next;
  logic [TAG_WIDTH-1:0]  pending_tag, pending_tag_next;
  logic                  pending_rescan, pending_rescan_next;
  logic [31:0]           saved_info_hash, saved_info_hash_next;
  logic [31:0]           saved_file_list_hash, saved_file_list_hash_next;
  logic                  info_dirty, info_dirty_next;
  logic                  files_dirty, files_dirty_next;
  logic [TIME_WIDTH-1:0] last_success_time, last_success_time_next;
  logic                  last_success_valid, last_success_valid_next;
  logic [TIME_WIDTH-1:0] last_telemetry_time, last_telemetry_time_next;
  logic                  last_telemetry_valid, last_telemetry_valid_next;

  logic    accept;
  result_t res;

  logic                  info_fire, files_fire, pv;
  logic [TIME_WIDTH-1:0] tel_since, succ_since;
  logic [15:0]           interval, base;
  logic [16:0]           doubled;
  logic [3:0]            xfer_type;

  assign accept = s_tvalid && s_tready;

  always_comb begin
    retry_delay_next          = retry_delay;
    retry_delay_valid_next    = retry_delay_valid;
    sleep_pending_next        = sleep_pending;
    fail_count_next           = fail_count;
    pending_valid_next        = pending_valid;
    pending_type_next         = pending_type;
    pending_tag_next          = pending_tag;
    pending_rescan_next       = pending_rescan;
    saved_info_hash_next      = saved_info_hash;
    saved_file_list_hash_next = saved_file_list_hash;
    info_dirty_next           = info_dirty;
    files_dirty_next          = files_dirty;
    last_success_time_next    = last_success_time;
    last_success_valid_next   = last_success_valid;
    last_telemetry_time_next  = last_telemetry_time;
    last_telemetry_valid_next = last_telemetry_valid;
    res = '0;

    info_fire  = info_dirty || (info_hash != saved_info_hash);
    files_fire = files_dirty || (!info_fire && (file_list_hash != saved_file_list_hash));
    tel_since  = now - last_telemetry_time;
    succ_since = last_success_valid ? (now - last_success_time) : '0;
    interval   = is_busy ? telemetry_busy_ms : telemetry_idle_ms;
    base       = retry_delay_valid ? retry_delay : (cooldown_base_ms >> 1);
    doubled    = {base, 1'b0};
    pv         = pending_valid;
    unique case (transfer_outcome)
      XFER_FINISHED: xfer_type = EV_XFER_FINISHED;
      XFER_ERROR:    xfer_type = EV_ABORTED;
      default:       xfer_type = EV_STOPPED;
    endcase

    if (accept) begin
      unique case (op)
        OP_QUERY: begin
          if (sleep_pending) begin
            sleep_pending_next = 1'b0;
            res.action   = ACT_SLEEP;
            res.sleep_ms = retry_delay;
          end else if (pending_valid) begin
            res.action       = ACT_EVENT;
            res.event_type   = pending_type;
            res.event_tag    = 32'(pending_tag);
            res.rescan_files = pending_rescan;
          end else begin
            if (info_hash != saved_info_hash) begin
              saved_info_hash_next = info_hash;
              info_dirty_next      = 1'b1;
            end
            if (!info_fire && (file_list_hash != saved_file_list_hash)) begin
              saved_file_list_hash_next = file_list_hash;
              files_dirty_next          = 1'b1;
            end
            if (info_fire || files_fire) begin
              pending_valid_next  = 1'b1;
              pending_type_next   = EV_INFO;
              pending_tag_next    = '0;
              pending_rescan_next = files_fire;
              res.action          = ACT_EVENT;
              res.event_type      = EV_INFO;
              res.rescan_files    = files_fire;
            end else if (transfer_outcome != XFER_NONE) begin
              pending_valid_next  = 1'b1;
              pending_type_next   = xfer_type;
              pending_tag_next    = TAG_WIDTH'(post_tag);
              pending_rescan_next = 1'b0;
              res.action          = ACT_EVENT;
              res.event_type      = xfer_type;
              res.event_tag       = 32'(TAG_WIDTH'(post_tag));
            end else if (!last_telemetry_valid ||
                         (tel_since >= TIME_WIDTH'(interval))) begin
              res.action = ACT_TELEMETRY;
            end else begin
              // since < interval here, so it fits in 16 bits
              res.action   = ACT_SLEEP;
              res.sleep_ms = interval - tel_since[15:0];
            end
          end
        end
        OP_DONE: begin
          unique case (done_result)
            DONE_OK, DONE_REFUSED: begin
              last_success_time_next  = now;
              last_success_valid_next = 1'b1;
              sleep_pending_next      = 1'b0;
              retry_delay_valid_next  = 1'b0;
              retry_delay_next        = '0;
              fail_count_next         = '0;
              if (pending_valid) begin
                if (pending_type == EV_INFO) begin
                  info_dirty_next = 1'b0;
                  if (pending_rescan) files_dirty_next = 1'b0;
                end
                pending_valid_next        = 1'b0;
                last_telemetry_valid_next = 1'b0;
              end else begin
                last_telemetry_time_next  = now;
                last_telemetry_valid_next = 1'b1;
              end
            end
            DONE_FAILED: begin
              if (({1'b0, fail_count} + 4'd1) >= {1'b0, give_up_attempts}) begin
                if (pending_valid && (pending_type != EV_INFO)) pv = 1'b0;
                fail_count_next = '0;
              end else begin
                fail_count_next = fail_count + 3'd1;
              end
              pending_valid_next = pv;
              if ((CMP_W'(succ_since) >= CMP_W'(reconnect_after_ms)) && !pv) begin
                pending_valid_next      = 1'b1;
                pending_type_next       = EV_INFO;
                pending_tag_next        = '0;
                pending_rescan_next     = 1'b0;
                last_success_valid_next = 1'b0;
              end
              retry_delay_next       = (doubled < {1'b0, cooldown_max_ms}) ?
                                       doubled[15:0] : cooldown_max_ms;
              retry_delay_valid_next = 1'b1;
              sleep_pending_next     = 1'b1;
            end
            default: ;
          endcase
        end
        OP_POST: begin
          if (post_type <= EV_LAST) begin
            pending_valid_next  = 1'b1;
            pending_type_next   = post_type;
            pending_tag_next    = TAG_WIDTH'(post_tag);
            pending_rescan_next = 1'b0;
          end
        end
        OP_RESET: begin
          info_dirty_next           = 1'b1;
          last_telemetry_valid_next = 1'b0;
          last_telemetry_time_next  = '0;
          retry_delay_valid_next    = 1'b0;
          retry_delay_next          = '0;
          sleep_pending_next        = 1'b0;
          fail_count_next           = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      retry_delay          <= '0;
      retry_delay_valid    <= 1'b0;
      sleep_pending        <= 1'b0;
      fail_count           <= '0;
      pending_valid        <= 1'b0;
      pending_type         <= '0;
      pending_tag          <= '0;
      pending_rescan       <= 1'b0;
      saved_info_hash      <= '0;
      saved_file_list_hash <= '0;
      info_dirty           <= 1'b1;
      files_dirty          <= 1'b0;
      last_success_time    <= '0;
      last_success_valid   <= 1'b0;
      last_telemetry_time  <= '0;
      last_telemetry_valid <= 1'b0;
    end else begin
      retry_delay          <= retry_delay_next;
      retry_delay_valid    <= retry_delay_valid_next;
      sleep_pending        <= sleep_pending_next;
      fail_count           <= fail_count_next;
      pending_valid        <= pending_valid_next;
      pending_type         <= pending_type_next;
      pending_tag          <= pending_tag_next;
      pending_rescan       <= pending_rescan_next;
      saved_info_hash      <= saved_info_hash_next;
      saved_file_list_hash <= saved_file_list_hash_next;
      info_dirty           <= info_dirty_next;
      files_dirty          <= files_dirty_next;
      last_success_time    <= last_success_time_next;
      last_success_valid   <= last_success_valid_next;
      last_telemetry_time  <= last_telemetry_time_next;
      last_telemetry_valid <= last_telemetry_valid_next;
    end
  end

  // two-entry output buffer
  result_t out_res, skid_res;
  logic    out_valid, skid_valid;
  logic    pop;

  assign pop      = out_valid && m_tready;
  assign s_tready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid || pop) out_valid <= 1'b1;
      else                   skid_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) out_res <= skid_res;
    end else if (accept) begin
      if (!out_valid || pop) out_res  <= res;
      else                   skid_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.action;
  assign m_tdata  = {3'b000, out_res.rescan_files, out_res.event_tag,
                     out_res.event_type, out_res.sleep_ms};

  `RBES_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid)
  `RBES_ASSERT_NEXT(a_fail_arms_sleep,
                    accept && (op == OP_DONE) && (done_result == DONE_FAILED),
                    sleep_pending && retry_delay_valid)
  `RBES_ASSERT_NOW(a_delay_cleared, !retry_delay_valid, retry_delay == 16'd0)
  `RBES_ASSERT_NEXT(a_cooldown_once,
                    accept && (op == OP_QUERY) && sleep_pending, !sleep_pending)

endmodule

### sim/retry_backoff_event_scheduler_checker.sv
module retry_backoff_event_scheduler_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [rbes_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic [1:0]                      s_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [rbes_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic [1:0]                      m_tuser,
  input  logic                            cfg_we,
  input  logic [2:0]                      cfg_index,
  input  logic [rbes_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              in_flight
);
  import rbes_pkg::*;

  logic [15:0] cfg_base, cfg_max, cfg_idle, cfg_busy;
  logic [19:0] cfg_reconnect;
  logic [2:0]  cfg_give_up;

  logic [15:0] backoff_ms;
  logic        backoff_valid, cooldown_due;
  logic [2:0]  failures;
  logic        held_valid, held_rescan;
  logic [3:0]  held_type;
  logic [31:0] held_tag;
  logic [31:0] info_fp, files_fp;
  logic        info_stale, files_stale;
  logic [31:0] ok_time, telem_time;
  logic        ok_valid, telem_valid;

  result_t planned_actions[$];
  result_t seen, want;

  function automatic void park_event(input logic [3:0] kind, input logic [31:0] tag,
                                     input logic rescan);
    held_valid  = 1'b1;
    held_type   = kind;
    held_tag    = tag;
    held_rescan = rescan;
  endfunction

  function automatic void restart_link();
    info_stale    = 1'b1;
    telem_valid   = 1'b0;
    telem_time    = '0;
    backoff_valid = 1'b0;
    backoff_ms    = '0;
    cooldown_due  = 1'b0;
    failures      = '0;
  endfunction

  function automatic result_t predict_item(input op_t op, input logic [IN_DATA_W-1:0] d);
    result_t     r;
    logic [31:0] now, since;
    logic [16:0] doubled;
    logic [15:0] interval;
    logic        fire;
    now = d[31:0];
    r   = '0;
    case (op)
      OP_QUERY: begin
        if (cooldown_due) begin
          cooldown_due = 1'b0;
          r.action     = ACT_SLEEP;
          r.sleep_ms   = backoff_ms;
        end else begin
          if (!held_valid) begin
            if (d[65:34] != info_fp) begin
              info_fp    = d[65:34];
              info_stale = 1'b1;
            end
            fire = info_stale;
            if (!fire) begin
              if (d[97:66] != files_fp) begin
                files_fp    = d[97:66];
                files_stale = 1'b1;
              end
              fire = files_stale;
            end
            if (fire) begin
              park_event(EV_INFO, '0, files_stale);
            end else begin
              case (d[100:99])
                XFER_FINISHED: park_event(EV_XFER_FINISHED, d[136:105], 1'b0);
                XFER_ERROR:    park_event(EV_ABORTED, d[136:105], 1'b0);
                XFER_STOPPED:  park_event(EV_STOPPED, d[136:105], 1'b0);
                default: ;
              endcase
            end
          end
          if (held_valid) begin
            r.action       = ACT_EVENT;
            r.event_type   = held_type;
            r.event_tag    = held_tag;
            r.rescan_files = held_rescan;
          end else begin
            interval = d[98] ? cfg_busy : cfg_idle;
            since    = now - telem_time;
            if (!telem_valid || since >= {16'b0, interval}) begin
              r.action = ACT_TELEMETRY;
            end else begin
              r.action   = ACT_SLEEP;
              r.sleep_ms = interval - since[15:0];
            end
          end
        end
      end
      OP_DONE: begin
        case (d[33:32])
          DONE_OK, DONE_REFUSED: begin
            ok_time       = now;
            ok_valid      = 1'b1;
            cooldown_due  = 1'b0;
            backoff_valid = 1'b0;
            backoff_ms    = '0;
            failures      = '0;
            if (held_valid) begin
              if (held_type == EV_INFO) begin
                info_stale = 1'b0;
                if (held_rescan) files_stale = 1'b0;
              end
              held_valid  = 1'b0;
              telem_valid = 1'b0;
            end else begin
              telem_time  = now;
              telem_valid = 1'b1;
            end
          end
          DONE_FAILED: begin
            if ({1'b0, failures} + 4'd1 >= {1'b0, cfg_give_up}) begin
              if (held_valid && held_type != EV_INFO) held_valid = 1'b0;
              failures = '0;
            end else begin
              failures = failures + 3'd1;
            end
            since = ok_valid ? now - ok_time : '0;
            if (since >= {12'b0, cfg_reconnect} && !held_valid) begin
              park_event(EV_INFO, '0, 1'b0);
              ok_valid = 1'b0;
            end
            doubled = backoff_valid ? {backoff_ms, 1'b0} : {1'b0, cfg_base[15:1], 1'b0};
            backoff_ms    = doubled < {1'b0, cfg_max} ? doubled[15:0] : cfg_max;
            backoff_valid = 1'b1;
            cooldown_due  = 1'b1;
          end
          default: ;
        endcase
      end
      OP_POST: begin
        if (d[104:101] <= EV_LAST) park_event(d[104:101], d[136:105], 1'b0);
      end
      default: restart_link();
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cfg_base      = COOLDOWN_BASE_RST;
      cfg_max       = COOLDOWN_MAX_RST;
      cfg_idle      = TELEM_IDLE_RST;
      cfg_busy      = TELEM_BUSY_RST;
      cfg_reconnect = RECONNECT_RST;
      cfg_give_up   = GIVE_UP_RST;
      restart_link();
      held_valid    = 1'b0;
      held_type     = '0;
      held_tag      = '0;
      held_rescan   = 1'b0;
      info_fp       = '0;
      files_fp      = '0;
      files_stale   = 1'b0;
      ok_time       = '0;
      ok_valid      = 1'b0;
      planned_actions.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_COOLDOWN_BASE: cfg_base      = cfg_data[15:0];
          CFG_COOLDOWN_MAX:  cfg_max       = cfg_data[15:0];
          CFG_TELEM_IDLE:    cfg_idle      = cfg_data[15:0];
          CFG_TELEM_BUSY:    cfg_busy      = cfg_data[15:0];
          CFG_RECONNECT:     cfg_reconnect = cfg_data[19:0];
          CFG_GIVE_UP:       cfg_give_up   = cfg_data[2:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        seen.action       = action_t'(m_tuser);
        seen.sleep_ms     = m_tdata[15:0];
        seen.event_type   = m_tdata[19:16];
        seen.event_tag    = m_tdata[51:20];
        seen.rescan_files = m_tdata[52];
        if (planned_actions.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected item: action %0d sleep %0d type %0d tag %h rescan %0d",
                     $time, seen.action, seen.sleep_ms, seen.event_type, seen.event_tag,
                     seen.rescan_files);
        end else begin
          want = planned_actions.pop_front();
          if (seen.action != want.action || seen.sleep_ms != want.sleep_ms ||
              seen.event_type != want.event_type || seen.event_tag != want.event_tag ||
              seen.rescan_files != want.rescan_files) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch, expected action %0d sleep %0d type %0d tag %h rescan %0d",
                       $time, want.action, want.sleep_ms, want.event_type, want.event_tag,
                       want.rescan_files);
              $display("%0t:           actual   action %0d sleep %0d type %0d tag %h rescan %0d",
                       $time, seen.action, seen.sleep_ms, seen.event_type, seen.event_tag,
                       seen.rescan_files);
            end
          end
        end
      end
      if (s_tvalid && s_tready)
        planned_actions.push_back(predict_item(op_t'(s_tuser), s_tdata));
    end
    in_flight = planned_actions.size();
  end

endmodule

### sim/retry_backoff_event_scheduler_test.sv
module retry_backoff_event_scheduler_test;
  import rbes_pkg::*;

  localparam int         CYCLE_LIMIT  = 400000;
  localparam logic [1:0] DONE_UNKNOWN = 2'd3;
  localparam logic [3:0] EV_BOGUS     = 4'd15;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [1:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [1:0]            m_tuser;
  logic                  cfg_we = 1'b0;
  logic [2:0]            cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int          mismatches, in_flight;
  int          cycles = 0;
  int unsigned send_gap = 30;
  int unsigned take_gap = 70;
  logic [31:0] now_ms = '0;
  logic [31:0] info_now = '0;
  logic [31:0] files_now = '0;

  retry_backoff_event_scheduler dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  retry_backoff_event_scheduler_checker u_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .in_flight(in_flight)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(negedge clk) m_tready <= ($urandom_range(0, 99) >= take_gap);

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic drive(input op_t op, input logic [31:0] now, input logic [1:0] done,
                       input logic [31:0] ih, input logic [31:0] fh, input logic busy,
                       input logic [1:0] xfer, input logic [3:0] ptype,
                       input logic [31:0] ptag);
    while ($urandom_range(0, 99) < send_gap) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {7'b0, ptag, ptype, xfer, busy, fh, ih, done, now};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (in_flight != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [15:0] base, input logic [15:0] ceiling,
                                input logic [15:0] idle, input logic [15:0] busy,
                                input logic [19:0] recon, input logic [2:0] give_up);
    write_reg(CFG_COOLDOWN_BASE, CFG_DATA_W'(base));
    write_reg(CFG_COOLDOWN_MAX, CFG_DATA_W'(ceiling));
    write_reg(CFG_TELEM_IDLE, CFG_DATA_W'(idle));
    write_reg(CFG_TELEM_BUSY, CFG_DATA_W'(busy));
    write_reg(CFG_RECONNECT, recon);
    write_reg(CFG_GIVE_UP, CFG_DATA_W'(give_up));
  endtask

  task automatic random_item(input int unsigned span);
    op_t         op;
    logic [1:0]  done;
    logic [1:0]  xfer;
    logic [3:0]  ptype;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) ;
    else if (roll < 70) now_ms += $urandom_range(0, span);
    else if (roll < 95) now_ms += $urandom_range(0, span * 8);
    else now_ms = $urandom();
    if ($urandom_range(0, 99) < 5) info_now = $urandom();
    if ($urandom_range(0, 99) < 8) files_now = $urandom();
    roll = $urandom_range(0, 99);
    op = roll < 45 ? OP_QUERY : roll < 77 ? OP_DONE : roll < 96 ? OP_POST : OP_RESET;
    roll = $urandom_range(0, 19);
    done = roll < 8 ? DONE_OK : roll < 11 ? DONE_REFUSED : roll < 19 ? DONE_FAILED
         : DONE_UNKNOWN;
    xfer = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(XFER_FINISHED, XFER_STOPPED))
         : XFER_NONE;
    ptype = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(EV_BOGUS, EV_LAST + 1))
          : 4'($urandom_range(EV_INFO, EV_LAST));
    drive(op, now_ms, done, info_now, files_now, 1'($urandom_range(0, 1)), xfer, ptype,
          $urandom());
  endtask

  initial begin
    int unsigned span;
    logic [15:0] idle_ms;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part, reset configuration
    drive(OP_QUERY, 0, DONE_OK, 0, 0, 1'b0, XFER_NONE, EV_INFO, 0);
    drive(OP_DONE, 10, DONE_OK, 0, 0, 1'b0, XFER_NONE, EV_INFO, 0);
    drive(OP_QUERY, 20, DONE_OK, 0, '1, 1'b0, XFER_NONE, EV_INFO, 0);
    drive(OP_DONE, 30, DONE_REFUSED, 0, '1, 1'b0, XFER_NONE, EV_INFO, 0);
    drive(OP_QUERY, 40, DONE_OK, 0, '1, 1'b0, XFER_FINISHED, EV_INFO, '1);
    drive(OP_DONE, 50, DONE_FAILED, 0, '1, 1'b0, XFER_NONE, EV_INFO, 0);
    drive(OP_QUERY, 60, DONE_OK, 0, '1, 1'b0, XFER_NONE, EV_INFO, 0);
    drive(OP_QUERY, 70, DONE_OK, 0, '1, 1'b0, XFER_NONE, EV_INFO, 0);
    repeat (4) drive(OP_DONE, 80, DONE_FAILED, 0, '1, 1'b0, XFER_NONE, EV_INFO, 0);
    drive(OP_QUERY, 120, DONE_OK, 0, '1, 1'b0, XFER_ERROR, EV_INFO, 32'h0000_1234);
    drive(OP_QUERY, 130, DONE_OK, 0, '1, 1'b0, XFER_ERROR, EV_INFO, 32'h0000_1234);
    drive(OP_DONE, 140, DONE_OK, 0, '1, 1'b0, XFER_NONE, EV_INFO, 0);
    drive(OP_QUERY, 150, DONE_OK, 0, '1, 1'b1, XFER_NONE, EV_INFO, 0);
    drive(OP_DONE, 160, DONE_OK, 0, '1, 1'b0, XFER_NONE, EV_INFO, 0);
    drive(OP_QUERY, 500, DONE_OK, 0, '1, 1'b1, XFER_NONE, EV_INFO, 0);
    drive(OP_QUERY, 4160, DONE_OK, 0, '1, 1'b0, XFER_NONE, EV_INFO, 0);
    drive(OP_DONE, 4200, DONE_UNKNOWN, 0, '1, 1'b0, XFER_NONE, EV_INFO, 0);
    drive(OP_POST, 4210, DONE_OK, 0, '1, 1'b0, XFER_NONE, EV_BOGUS, '1);
    drive(OP_POST, 4220, DONE_OK, 0, '1, 1'b0, XFER_NONE, EV_XFER_FINISHED, 32'hA5A5_0001);
    drive(OP_QUERY, 4230, DONE_OK, 0, '1, 1'b0, XFER_STOPPED, EV_INFO, 0);
    drive(OP_RESET, 4240, DONE_OK, 0, '1, 1'b0, XFER_NONE, EV_INFO, 0);
    drive(OP_DONE, 32'hFFFF_FF00, DONE_OK, 0, '1, 1'b0, XFER_NONE, EV_INFO, 0);
    drive(OP_QUERY, 32'h0000_0100, DONE_OK, '1, '1, 1'b0, XFER_NONE, EV_INFO, 0);
    drive(OP_DONE, 32'h0000_0110, DONE_OK, '1, '1, 1'b0, XFER_NONE, EV_INFO, 0);
    drive(OP_DONE, 32'h0000_0110 + 10000, DONE_FAILED, '1, '1, 1'b0, XFER_NONE, EV_INFO, 0);
    drive(OP_QUERY, 32'h0000_3000, DONE_OK, '1, '1, 1'b0, XFER_NONE, EV_INFO, 0);
    drive(OP_QUERY, 32'h0000_3010, DONE_OK, '1, '1, 1'b0, XFER_NONE, EV_INFO, 0);

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      send_gap = ph < 2 ? 30 : ph < 4 ? 70 : 0;
      take_gap = ph < 2 ? 70 : ph < 4 ? 30 : 0;
      case (ph)
        0: begin
          apply_settings(COOLDOWN_BASE_RST, COOLDOWN_MAX_RST, TELEM_IDLE_RST,
                         TELEM_BUSY_RST, RECONNECT_RST, GIVE_UP_RST);
          span = 3000;
        end
        1: begin
          apply_settings(16'd2, 16'd1, 16'd1, 16'd1, 20'd1, 3'd1);
          span = 3;
        end
        2: begin
          apply_settings('1, '1, '1, '1, '1, 3'd7);
          span = 50000;
          now_ms = 32'hFFFF_0000;
        end
        3: begin
          idle_ms = 16'($urandom_range(1, 65535));
          apply_settings(16'($urandom_range(2, 65535)), 16'($urandom_range(1, 65535)),
                         idle_ms, 16'($urandom_range(1, 65535)),
                         20'($urandom_range(1, 1048575)), 3'd0);
          span = {16'b0, idle_ms};
        end
        4: begin
          apply_settings(16'd10, 16'd300, 16'd50, 16'd20, 20'd500, 3'd3);
          span = 60;
        end
        default: begin
          idle_ms = 16'($urandom_range(1, 2000));
          apply_settings(16'($urandom_range(2, 4000)), 16'($urandom_range(1, 65535)),
                         idle_ms, 16'($urandom_range(1, 2000)),
                         20'($urandom_range(1, 20000)), 3'($urandom_range(1, 7)));
          span = {16'b0, idle_ms};
        end
      endcase
      repeat (225) random_item(span);
    end

    settle();
    repeat (4) @(negedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/rbes_pkg.sv
rtl/retry_backoff_event_scheduler.sv
sim/retry_backoff_event_scheduler_checker.sv
sim/retry_backoff_event_scheduler_test.sv
